// ===== hdl/sacs_pkg.sv =====
package sacs_pkg;

	localparam int NODE_COUNT = 8;
	localparam int DRAW_W     = 4;
	localparam int WAIT_W     = 5;
	localparam int ATT_W      = 4;
	localparam int CNT_W      = $clog2(NODE_COUNT + 1);
	localparam int WIN_W      = $clog2(NODE_COUNT);

	// register indexes, taken from paddr[2]
	localparam logic REG_MAX_ATTEMPTS = 1'b0;
	localparam logic REG_ACTIVE_MASK  = 1'b1;

	typedef struct packed {
		logic collision;
		logic success;
	} verdict_t;

	// draw mod m by restoring subtraction; draw < 16 keeps each step in range
	function automatic logic [DRAW_W-1:0] draw_mod(input logic [DRAW_W-1:0] draw,
			input logic [ATT_W-1:0] m);
		logic [2*DRAW_W-1:0] r;
		logic [2*DRAW_W-1:0] d;
		r = {{DRAW_W{1'b0}}, draw};
		for (int s = DRAW_W - 1; s >= 0; s--) begin
			d = {{(2*DRAW_W-ATT_W){1'b0}}, m} << s;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[DRAW_W-1:0];
	endfunction

endpackage

// ===== hdl/sacs_lane.sv =====
module sacs_lane import sacs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              commit,
	input  verdict_t          verdict,
	input  logic              active,
	input  logic              coin,
	input  logic [DRAW_W-1:0] draw,
	input  logic [ATT_W-1:0]  max_attempts,
	output logic              send,
	output logic              abort
);

	logic [WAIT_W-1:0] wait_q;
	logic [ATT_W-1:0]  att_q;

	logic              send_s1;
	logic              abort_s1;
	logic [ATT_W-1:0]  col_att_s1;
	logic [WAIT_W-1:0] col_wait_s1;

	logic [WAIT_W-1:0] dec_wait;
	logic              send_now;
	logic [ATT_W:0]    next_att;
	logic              abort_now;
	logic [WAIT_W-1:0] backoff;

	always_comb begin
		dec_wait  = (active && wait_q != '0) ? wait_q - WAIT_W'(1) : wait_q;
		send_now  = active && coin && (dec_wait == '0);
		next_att  = {1'b0, att_q} + (ATT_W+1)'(1);
		abort_now = next_att > {1'b0, max_attempts};
		backoff   = {{(WAIT_W-DRAW_W){1'b0}}, draw_mod(draw, max_attempts)} + WAIT_W'(2);
	end

	// count down on accept, settle the backoff once the merge has judged the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
			att_q  <= '0;
		end else if (take) begin
			wait_q <= dec_wait;
		end else if (commit && send_s1 && (verdict.collision || verdict.success)) begin
			if (verdict.collision && !abort_s1) begin
				att_q  <= col_att_s1;
				wait_q <= col_wait_s1;
			end else begin
				att_q  <= '0;
				wait_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			send_s1     <= send_now;
			abort_s1    <= abort_now;
			col_att_s1  <= next_att[ATT_W-1:0];
			col_wait_s1 <= backoff;
		end
	end

	assign send  = send_s1;
	assign abort = send_s1 && abort_s1;

endmodule

// ===== hdl/sacs_merge.sv =====
module sacs_merge import sacs_pkg::*; (
	input  logic [NODE_COUNT-1:0] senders,
	output logic [CNT_W-1:0]      count,
	output logic [WIN_W-1:0]      winner,
	output verdict_t              verdict
);

	logic [WIN_W-1:0] last_idx;

	always_comb begin
		count    = '0;
		last_idx = '0;
		for (int i = 0; i < NODE_COUNT; i++) begin
			count = count + CNT_W'(senders[i]);
			if (senders[i]) begin
				last_idx = WIN_W'(i);
			end
		end
		verdict.collision = count > CNT_W'(1);
		verdict.success   = count == CNT_W'(1);
		winner            = verdict.success ? last_idx : '0;
	end

endmodule

// ===== hdl/slotted_aloha_contention_slot.sv =====
// Channel   Handshake                 Payload
// -------   -----------------------   --------------------------------------------
// in        in_valid / in_ready       send_coins, backoff_draws (one slot)
// out       out_valid / out_ready     sender_mask, collision, success, winner,
//                                     aborted_mask, packets_offered, packets_delivered
// cfg       psel/penable/pwrite       paddr 0: max_attempts, paddr 4: active_mask
//
// Per slot, the accept edge loads the per-node lanes (count down, send decision,
// backoff draw mod max_attempts); in the merge state the lane results are merged
// (sender count, winner) and the commit edge writes node state and running totals.
// The merge cycle stretches while the output register still holds an untaken
// result; in_ready stays low from accept until the merge commits.
// arst_n clears all node counters, both totals and the output valid flag, and
// loads max_attempts = 15, active_mask = 255.
module slotted_aloha_contention_slot import sacs_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// slot request
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [NODE_COUNT-1:0]      send_coins,
	input  logic [DRAW_W*NODE_COUNT-1:0] backoff_draws,
	// slot result
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [NODE_COUNT-1:0]      sender_mask,
	output logic                       collision,
	output logic                       success,
	output logic [WIN_W-1:0]           winner,
	output logic [NODE_COUNT-1:0]      aborted_mask,
	output logic [31:0]                packets_offered,
	output logic [31:0]                packets_delivered
);

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	state_t state_q;

	logic [ATT_W-1:0]      max_attempts_q;
	logic [NODE_COUNT-1:0] active_mask_q;

	logic                  out_valid_q;
	logic [NODE_COUNT-1:0] sender_mask_q;
	logic                  collision_q;
	logic                  success_q;
	logic [WIN_W-1:0]      winner_q;
	logic [NODE_COUNT-1:0] aborted_mask_q;
	logic [31:0]           offered_total_q;
	logic [31:0]           delivered_total_q;

	logic                  take;
	logic                  commit;
	logic                  cfg_write;
	logic [NODE_COUNT-1:0] lane_send;
	logic [NODE_COUNT-1:0] lane_abort;
	logic [CNT_W-1:0]      send_count;
	logic [WIN_W-1:0]      merge_winner;
	verdict_t              verdict;

	// ---------------------------------------------------------------
	// configuration port: zero-wait APB, register picked by paddr[2]
	// ---------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q <= ATT_W'(15);
			active_mask_q  <= '1;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_MAX_ATTEMPTS: max_attempts_q <= pwdata[ATT_W-1:0];
				REG_ACTIVE_MASK:  active_mask_q  <= pwdata[NODE_COUNT-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_ATTEMPTS: prdata = {{(32-ATT_W){1'b0}}, max_attempts_q};
			REG_ACTIVE_MASK:  prdata = {{(32-NODE_COUNT){1'b0}}, active_mask_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// handshake: accept only in idle, commit when the output slot frees
	// ---------------------------------------------------------------
	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign commit   = (state_q == ST_MERGE) && (!out_valid_q || out_ready);

	// ---------------------------------------------------------------
	// one lane per node; each owns its wait and attempt counters
	// ---------------------------------------------------------------
	for (genvar g = 0; g < NODE_COUNT; g++) begin : g_lane
		sacs_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.take         (take),
			.commit       (commit),
			.verdict      (verdict),
			.active       (active_mask_q[g]),
			.coin         (send_coins[g]),
			.draw         (backoff_draws[DRAW_W*g +: DRAW_W]),
			.max_attempts (max_attempts_q),
			.send         (lane_send[g]),
			.abort        (lane_abort[g])
		);
	end

	// count the senders and pick the winner
	sacs_merge u_merge (
		.senders (lane_send),
		.count   (send_count),
		.winner  (merge_winner),
		.verdict (verdict)
	);

	// ---------------------------------------------------------------
	// sequencer, totals and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			out_valid_q       <= 1'b0;
			sender_mask_q     <= '0;
			collision_q       <= 1'b0;
			success_q         <= 1'b0;
			winner_q          <= '0;
			aborted_mask_q    <= '0;
			offered_total_q   <= '0;
			delivered_total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_MERGE;
					end
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_MERGE: begin
					if (commit) begin
						// load the result and advance the running totals
						state_q         <= ST_IDLE;
						out_valid_q     <= 1'b1;
						sender_mask_q   <= lane_send;
						collision_q     <= verdict.collision;
						success_q       <= verdict.success;
						winner_q        <= merge_winner;
						aborted_mask_q  <= verdict.collision ? lane_abort : '0;
						offered_total_q <= offered_total_q
							+ {{(32-CNT_W){1'b0}}, send_count};
						delivered_total_q <= delivered_total_q
							+ {31'b0, verdict.success};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign sender_mask       = sender_mask_q;
	assign collision         = collision_q;
	assign success           = success_q;
	assign winner            = winner_q;
	assign aborted_mask      = aborted_mask_q;
	assign packets_offered   = offered_total_q;
	assign packets_delivered = delivered_total_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(collision && success))
		else $error("collision and success both set");

	a_winner_sent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && success |-> $onehot(sender_mask) && sender_mask[winner])
		else $error("winner is not the lone sender");

	a_abort_subset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((aborted_mask & ~sender_mask) == '0)
			&& (collision || aborted_mask == '0))
		else $error("abort outside a collision or by a non-sender");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second slot accepted before merge");

	a_delivered_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> packets_delivered == $past(delivered_total_q)
			+ {31'b0, $past(verdict.success)})
		else $error("delivered total out of step");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sacs_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 4;

	// One slot result as the block should report it.
	typedef struct packed {
		logic [NODE_COUNT-1:0] senders;
		logic                  collision;
		logic                  success;
		logic [WIN_W-1:0]      winner;
		logic [NODE_COUNT-1:0] aborted;
		logic [31:0]           offered;
		logic [31:0]           delivered;
	} slot_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [2:0]                   paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [NODE_COUNT-1:0]        send_coins = '0;
	logic [DRAW_W*NODE_COUNT-1:0] backoff_draws = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [NODE_COUNT-1:0]        sender_mask;
	logic                         collision;
	logic                         success;
	logic [WIN_W-1:0]             winner;
	logic [NODE_COUNT-1:0]        aborted_mask;
	logic [31:0]                  packets_offered;
	logic [31:0]                  packets_delivered;

	// Shadow of the contention state, advanced once per accepted request.
	logic [WAIT_W-1:0]     node_wait [NODE_COUNT];
	logic [ATT_W-1:0]      node_tries [NODE_COUNT];
	logic [31:0]           offered_sum = '0;
	logic [31:0]           delivered_sum = '0;
	logic [ATT_W-1:0]      cfg_max_att = 4'd15;
	logic [NODE_COUNT-1:0] cfg_active = '1;

	slot_result_t expected_slots [$];

	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	slotted_aloha_contention_slot u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.send_coins        (send_coins),
		.backoff_draws     (backoff_draws),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.sender_mask       (sender_mask),
		.collision         (collision),
		.success           (success),
		.winner            (winner),
		.aborted_mask      (aborted_mask),
		.packets_offered   (packets_offered),
		.packets_delivered (packets_delivered)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < NODE_COUNT; i++) begin
			node_wait[i]  = '0;
			node_tries[i] = '0;
		end
	end

	// Resolve one slot against the shadow state: count down the waiting nodes,
	// collect the transmitters, then either reward the lone sender or push every
	// colliding sender into backoff (or abort it once it runs out of attempts).
	function automatic slot_result_t resolve_slot(input logic [NODE_COUNT-1:0] coins,
			input logic [DRAW_W*NODE_COUNT-1:0] draws);
		slot_result_t res;
		int tx_count;
		int last_tx;
		logic [ATT_W:0] next_try;
		logic [DRAW_W-1:0] draw;
		res = '0;
		tx_count = 0;
		last_tx = 0;
		// disabled nodes stay frozen in both passes
		for (int i = 0; i < NODE_COUNT; i++) begin
			if (cfg_active[i] && node_wait[i] != '0) begin
				node_wait[i] = node_wait[i] - WAIT_W'(1);
			end
		end
		for (int i = 0; i < NODE_COUNT; i++) begin
			if (cfg_active[i] && node_wait[i] == '0 && coins[i]) begin
				res.senders[i] = 1'b1;
				tx_count++;
				last_tx = i;
			end
		end
		offered_sum = offered_sum + 32'(tx_count);
		if (tx_count > 1) begin
			res.collision = 1'b1;
			for (int i = 0; i < NODE_COUNT; i++) begin
				if (res.senders[i]) begin
					next_try = {1'b0, node_tries[i]} + (ATT_W+1)'(1);
					// with max_attempts at zero this always aborts, so no modulo by zero
					if (next_try > {1'b0, cfg_max_att}) begin
						node_tries[i] = '0;
						node_wait[i]  = '0;
						res.aborted[i] = 1'b1;
					end else begin
						draw = draws[DRAW_W*i +: DRAW_W];
						node_tries[i] = next_try[ATT_W-1:0];
						node_wait[i]  = WAIT_W'(draw % cfg_max_att) + WAIT_W'(2);
					end
				end
			end
		end else if (tx_count == 1) begin
			res.success = 1'b1;
			res.winner  = WIN_W'(last_tx);
			delivered_sum = delivered_sum + 32'd1;
			node_wait[last_tx]  = '0;
			node_tries[last_tx] = '0;
		end
		res.offered   = offered_sum;
		res.delivered = delivered_sum;
		return res;
	endfunction

	// Hold until every outstanding slot result has come back, then let the
	// pipeline settle so register writes land on an idle block.
	task automatic drain;
		while (expected_slots.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Two-phase register write: setup phase, then access phase; the register
	// takes the value at the edge where the access phase meets pready.
	task automatic write_reg(input logic reg_index, input logic [31:0] value);
		drain();
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {reg_index, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_index == REG_MAX_ATTEMPTS) begin
			cfg_max_att = value[ATT_W-1:0];
		end else begin
			cfg_active = value[NODE_COUNT-1:0];
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Offer one slot request. Idle a random number of cycles first, then hold
	// valid and the payload steady until the block takes the request.
	task automatic send_slot(input logic [NODE_COUNT-1:0] coins,
			input logic [DRAW_W*NODE_COUNT-1:0] draws);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		send_coins    = coins;
		backoff_draws = draws;
		in_valid      = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_slots.insert(expected_slots.size(), resolve_slot(coins, draws));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endtask

	// Receiver: stall at random, or hold off entirely while a long hold is pending.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Score every result taken at the output against the oldest prediction.
	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_slots.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual sender_mask %0h",
					$time, sender_mask);
				error_count++;
			end else begin
				want = expected_slots.pop_front();
				check_field("sender_mask", 32'(want.senders), 32'(sender_mask));
				check_field("collision", 32'(want.collision), 32'(collision));
				check_field("success", 32'(want.success), 32'(success));
				check_field("winner", 32'(want.winner), 32'(winner));
				check_field("aborted_mask", 32'(want.aborted), 32'(aborted_mask));
				check_field("packets_offered", want.offered, packets_offered);
				check_field("packets_delivered", want.delivered, packets_delivered);
			end
		end
	end

	// Watchdog: the slowest legal run is far below this many cycles.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_slots.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Hand-picked slots: idle slot, lone senders at both ends, full collisions,
	// backoff expiry, abort at the smallest limit, a disabled set of nodes, and
	// the zero-limit case where every collision aborts.
	task automatic test_directed;
		send_idle_pct  = 36;
		recv_stall_pct = 60;
		send_slot('0, '0);
		send_slot(8'h01, 32'hFFFF_FFFF);
		send_slot(8'h80, '0);
		// everyone collides; draw 15 mod 15 gives the shortest backoff of 2
		send_slot(8'hFF, 32'hFFFF_FFFF);
		send_slot(8'hFF, '0);
		send_slot(8'hFF, 32'h8765_4321);
		send_slot(8'hFF, 32'h0F0F_0F0F);

		// smallest limit: a second collision aborts the pair
		write_reg(REG_MAX_ATTEMPTS, 32'd1);
		write_reg(REG_ACTIVE_MASK, 32'h0000_0003);
		for (int n = 0; n < 6; n++) begin
			send_slot(8'hFF, $urandom);
		end

		// nobody contends: counters stay frozen
		write_reg(REG_ACTIVE_MASK, 32'h0000_0000);
		send_slot(8'hFF, $urandom);
		send_slot(8'h5A, $urandom);

		// zero limit: every collision is an abort
		write_reg(REG_MAX_ATTEMPTS, 32'd0);
		write_reg(REG_ACTIVE_MASK, 32'h0000_00FF);
		send_slot(8'hFF, $urandom);
		send_slot(8'hC0, $urandom);
		send_slot(8'h10, $urandom);

		write_reg(REG_MAX_ATTEMPTS, 32'd15);
		write_reg(REG_ACTIVE_MASK, 32'h0000_0055);
		for (int n = 0; n < 4; n++) begin
			send_slot(8'hFF, $urandom);
		end
	endtask

	// Random slots in chunks, each chunk under a fresh setting. Coin patterns
	// mix dense traffic (collisions, long backoff chains, aborts) with sparse
	// traffic (lone senders that clear their node).
	task automatic test_random_traffic(input int items, input int sender_pct,
			input int receiver_pct);
		logic [NODE_COUNT-1:0] coins;
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
		for (int n = 0; n < items; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(2))
					0: write_reg(REG_MAX_ATTEMPTS, 32'd1);
					1: write_reg(REG_MAX_ATTEMPTS, 32'd15);
					default: write_reg(REG_MAX_ATTEMPTS, $urandom_range(1, 15));
				endcase
				case ($urandom_range(2))
					0: write_reg(REG_ACTIVE_MASK, 32'h0000_00FF);
					1: write_reg(REG_ACTIVE_MASK, $urandom);
					default: write_reg(REG_ACTIVE_MASK, $urandom | $urandom);
				endcase
			end
			case ($urandom_range(3))
				0: coins = NODE_COUNT'($urandom);
				1: coins = NODE_COUNT'($urandom | $urandom);
				2: coins = 8'h01 << $urandom_range(NODE_COUNT - 1);
				default: coins = NODE_COUNT'($urandom & $urandom);
			endcase
			send_slot(coins, $urandom);
		end
	endtask

	// Hold the receiver off for a long stretch while requests keep coming, so
	// the result register fills and the block stops taking requests.
	task automatic test_backpressure;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_reg(REG_MAX_ATTEMPTS, 32'd3);
		write_reg(REG_ACTIVE_MASK, 32'h0000_00FF);
		@(posedge clk);
		hold_left = 400;
		@(negedge clk);
		for (int n = 0; n < 40; n++) begin
			send_slot(NODE_COUNT'($urandom), $urandom);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic(300, 36, 60);
		test_random_traffic(300, 60, 36);
		test_random_traffic(300, 0, 0);
		test_backpressure();

		// let the tail drain, then watch a little longer for stray results
		while (expected_slots.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
